### src/eta_pkg.sv
package eta_pkg;

   localparam int MAX_NODES_DEFAULT = 256;
   localparam int MAX_ADJ_DEFAULT   = 512;
   localparam int MAX_SEQ_DEFAULT   = 511;
   localparam int NODE_W            = 8;
   localparam int COUNT_W           = 9;
   localparam int LEN_W             = 9;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TOUR   = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_RANGE     = 2'd1,
      STS_TOUR      = 2'd2,
      STS_UNREACHED = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [NODE_W-1:0] ancestor;
      logic [LEN_W-1:0]  tour_length;
      logic [LEN_W-1:0]  nodes_reported;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] node_count;
   } csr_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_AP_UPD,
      S_T_START,
      S_W_TOP,
      S_W_ADJ,
      S_W_HEAD,
      S_W_POP,
      S_B_L0,
      S_B_RA,
      S_B_RB,
      S_B_DA,
      S_B_DB,
      S_B_WR,
      S_Q_A,
      S_Q_B,
      S_Q_K,
      S_Q_RX,
      S_Q_RY,
      S_Q_DX,
      S_Q_DY,
      S_Q_NODE,
      S_DONE
   } state_type;

endpackage

### src/eta_chan_if.sv
interface eta_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### src/eta_ram.sv
module eta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/eta_core.sv
module eta_core #(
   parameter int MAX_NODES = eta_pkg::MAX_NODES_DEFAULT,
   parameter int MAX_ADJ   = eta_pkg::MAX_ADJ_DEFAULT,
   parameter int MAX_SEQ   = eta_pkg::MAX_SEQ_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  eta_pkg::req_type            req,
   input  logic [eta_pkg::COUNT_W-1:0] node_count,
   output logic                        res_valid,
   input  logic                        res_ready,
   output eta_pkg::rsp_type            res
);

   import eta_pkg::*;

   localparam int NIW  = $clog2(MAX_NODES);
   localparam int NCW  = $clog2(MAX_NODES + 1);
   localparam int CW   = (NCW > COUNT_W) ? NCW : COUNT_W;
   localparam int AW   = $clog2(MAX_ADJ);
   localparam int EUW  = $clog2(MAX_ADJ + 1);
   localparam int LKW  = AW + 1;
   localparam int SW   = $clog2(MAX_SEQ);
   localparam int SLW  = $clog2(MAX_SEQ + 1);
   localparam int LV   = $clog2(MAX_SEQ + 1);
   localparam int KW   = $clog2(LV);
   localparam int KCW  = $clog2(LV + 1);
   localparam int RTD  = LV << SW;
   localparam int RTAW = $clog2(RTD);
   localparam int SPW  = $clog2(MAX_NODES + 1);
   localparam int DW   = NIW;
   localparam int SQW  = NODE_W + DW;
   localparam int FW   = 2 * NODE_W + 1 + LKW + DW;
   localparam int P_NXT = DW;
   localparam int P_PV  = DW + LKW;
   localparam int P_PAR = DW + LKW + 1;
   localparam int P_NOD = DW + LKW + 1 + NODE_W;

   state_type state_ff, state_in;
   logic [NODE_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [EUW-1:0] entries_ff, entries_in;
   logic [MAX_NODES-1:0] hv_ff, hv_in, reached_ff, reached_in;
   logic [SLW-1:0] seq_len_ff, seq_len_in;
   logic tour_ready_ff, tour_ready_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [NODE_W-1:0] top_node_ff, top_node_in, top_par_ff, top_par_in;
   logic top_pv_ff, top_pv_in;
   logic [LKW-1:0] top_next_ff, top_next_in;
   logic [DW-1:0] top_dep_ff, top_dep_in;
   logic [NODE_W-1:0] child_ff, child_in;
   logic [KCW-1:0] k_ff, k_in;
   logic [SLW-1:0] i_ff, i_in;
   logic [SW-1:0] x_ff, x_in, y_ff, y_in, l_ff, l_in, r_ff, r_in;
   logic [DW-1:0] dx_ff, dx_in;
   rsp_type res_ff, res_in;

   logic nb_we, lk_we, ht_we, fp_we, sq_we, rt_we, st_we;
   logic [AW-1:0] nb_wa, lk_wa, nb_ra;
   logic [NODE_W-1:0] nb_wd, nb_rd;
   logic [LKW-1:0] lk_wd, lk_rd;
   logic [NIW-1:0] ht_wa, ht_ra, fp_wa, fp_ra, st_wa, st_ra;
   logic [2*AW-1:0] ht_wd, ht_rd;
   logic [SW-1:0] fp_wd, fp_rd, sq_wa, sq_ra, rt_wd, rt_rd;
   logic [SQW-1:0] sq_wd, sq_rd;
   logic [RTAW-1:0] rt_wa, rt_ra;
   logic [FW-1:0] st_wd, st_rd;

   logic [CW-1:0] live_n;
   logic a_ok, b_ok, child_ok;
   logic [SLW:0] span_end, lvl_next;
   logic [KCW-1:0] k_next;
   logic [SW-1:0] q_lo, q_hi;
   logic [SLW-1:0] span;
   logic [KW-1:0] q_k;
   logic [DW-1:0] dep_next;
   logic [AW-1:0] idx;

   eta_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ADJ)) nb_ram (
      .clock, .wr_en(nb_we), .wr_addr(nb_wa), .wr_data(nb_wd), .rd_addr(nb_ra), .rd_data(nb_rd)
   );
   eta_ram #(.WIDTH(LKW), .DEPTH(MAX_ADJ)) lk_ram (
      .clock, .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd), .rd_addr(nb_ra), .rd_data(lk_rd)
   );
   eta_ram #(.WIDTH(2 * AW), .DEPTH(MAX_NODES)) ht_ram (
      .clock, .wr_en(ht_we), .wr_addr(ht_wa), .wr_data(ht_wd), .rd_addr(ht_ra), .rd_data(ht_rd)
   );
   eta_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) fp_ram (
      .clock, .wr_en(fp_we), .wr_addr(fp_wa), .wr_data(fp_wd), .rd_addr(fp_ra), .rd_data(fp_rd)
   );
   eta_ram #(.WIDTH(SQW), .DEPTH(MAX_SEQ)) sq_ram (
      .clock, .wr_en(sq_we), .wr_addr(sq_wa), .wr_data(sq_wd), .rd_addr(sq_ra), .rd_data(sq_rd)
   );
   eta_ram #(.WIDTH(SW), .DEPTH(RTD)) rt_ram (
      .clock, .wr_en(rt_we), .wr_addr(rt_wa), .wr_data(rt_wd), .rd_addr(rt_ra), .rd_data(rt_rd)
   );
   eta_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) st_ram (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd), .rd_addr(st_ra), .rd_data(st_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         entries_ff    <= '0;
         hv_ff         <= '0;
         reached_ff    <= '0;
         seq_len_ff    <= '0;
         tour_ready_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         entries_ff    <= entries_in;
         hv_ff         <= hv_in;
         reached_ff    <= reached_in;
         seq_len_ff    <= seq_len_in;
         tour_ready_ff <= tour_ready_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      sp_ff       <= sp_in;
      top_node_ff <= top_node_in;
      top_par_ff  <= top_par_in;
      top_pv_ff   <= top_pv_in;
      top_next_ff <= top_next_in;
      top_dep_ff  <= top_dep_in;
      child_ff    <= child_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      dx_ff       <= dx_in;
      res_ff      <= res_in;
   end

   always_comb begin
      live_n = (CW'(node_count) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count);
      a_ok = CW'(req.node_a) < live_n;
      b_ok = CW'(req.node_b) < live_n;
      child_ok = CW'(nb_rd) < live_n;
      idx = AW'(entries_ff);
      dep_next = top_dep_ff + DW'(1);
      k_next = k_ff + KCW'(1);
      span_end = (SLW + 1)'(i_ff) + (SLW + 1)'(1) + ((SLW + 1)'(1) << k_ff);
      lvl_next = (SLW + 1)'(1) << k_next;
      q_lo = (l_ff < fp_rd) ? l_ff : fp_rd;
      q_hi = (l_ff < fp_rd) ? fp_rd : l_ff;
      span = SLW'(q_hi) - SLW'(q_lo) + SLW'(1);
      q_k = '0;
      for (int j = 0; j < SLW; j++) begin
         if (span[j]) begin
            q_k = KW'(j);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      entries_in    = entries_ff;
      hv_in         = hv_ff;
      reached_in    = reached_ff;
      seq_len_in    = seq_len_ff;
      tour_ready_in = tour_ready_ff;
      sp_in         = sp_ff;
      top_node_in   = top_node_ff;
      top_par_in    = top_par_ff;
      top_pv_in     = top_pv_ff;
      top_next_in   = top_next_ff;
      top_dep_in    = top_dep_ff;
      child_in      = child_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      dx_in         = dx_ff;
      res_in        = res_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      nb_we = 1'b0; nb_wa = idx; nb_wd = b_ff; nb_ra = top_next_ff[AW-1:0];
      lk_we = 1'b0; lk_wa = idx; lk_wd = {1'b1, AW'(0)};
      ht_we = 1'b0; ht_wa = NIW'(a_ff); ht_wd = {idx, idx}; ht_ra = NIW'(a_ff);
      fp_we = 1'b0; fp_wa = NIW'(a_ff); fp_wd = SW'(seq_len_ff); fp_ra = NIW'(a_ff);
      sq_we = 1'b0; sq_wa = SW'(seq_len_ff); sq_wd = '0; sq_ra = x_ff;
      rt_we = 1'b0; rt_wa = RTAW'({KW'(k_ff), SW'(i_ff)}); rt_wd = SW'(i_ff);
      rt_ra = RTAW'({KW'(k_ff), l_ff});
      st_we = 1'b0; st_wa = NIW'(sp_ff - SPW'(1));
      st_wd = {top_node_ff, top_par_ff, top_pv_ff, lk_rd, top_dep_ff};
      st_ra = NIW'(sp_ff - SPW'(2));

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               a_in   = req.node_a;
               b_in   = req.node_b;
               res_in = '0;
               state_in = S_DONE;
               unique case (req.command)
                  CMD_CLEAR: begin
                     hv_in = '0;
                     entries_in = '0;
                  end
                  CMD_APPEND: begin
                     if (!a_ok || !b_ok) begin
                        res_in.status = STS_RANGE;
                     end else if (entries_ff >= EUW'(MAX_ADJ)) begin
                        res_in.status = STS_TOUR;
                     end else begin
                        nb_we = 1'b1;
                        nb_wd = req.node_b;
                        lk_we = 1'b1;
                        ht_ra = NIW'(req.node_a);
                        state_in = S_AP_UPD;
                     end
                  end
                  CMD_TOUR: begin
                     reached_in = '0;
                     seq_len_in = '0;
                     tour_ready_in = 1'b0;
                     if (live_n == '0 || !a_ok) begin
                        res_in.status = STS_RANGE;
                     end else begin
                        sq_we = 1'b1;
                        sq_wa = '0;
                        sq_wd = {req.node_a, DW'(0)};
                        fp_we = 1'b1;
                        fp_wa = NIW'(req.node_a);
                        fp_wd = '0;
                        reached_in[NIW'(req.node_a)] = 1'b1;
                        seq_len_in = SLW'(1);
                        ht_ra = NIW'(req.node_a);
                        state_in = S_T_START;
                     end
                  end
                  CMD_QUERY: begin
                     if (!a_ok || !b_ok) begin
                        res_in.status = STS_RANGE;
                     end else if (!tour_ready_ff || seq_len_ff == '0) begin
                        res_in.status = STS_TOUR;
                     end else if (!reached_ff[NIW'(req.node_a)]
                                  || !reached_ff[NIW'(req.node_b)]) begin
                        res_in.status = STS_UNREACHED;
                     end else begin
                        fp_ra = NIW'(req.node_a);
                        state_in = S_Q_A;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_AP_UPD: begin
            ht_we = 1'b1;
            if (hv_ff[NIW'(a_ff)]) begin
               lk_we = 1'b1;
               lk_wa = ht_rd[AW-1:0];
               lk_wd = {1'b0, idx};
               ht_wd = {ht_rd[2*AW-1:AW], idx};
            end else begin
               hv_in[NIW'(a_ff)] = 1'b1;
            end
            entries_in = entries_ff + EUW'(1);
            state_in = S_DONE;
         end
         S_T_START: begin
            top_node_in = a_ff;
            top_par_in  = '0;
            top_pv_in   = 1'b0;
            top_next_in = hv_ff[NIW'(a_ff)] ? {1'b0, ht_rd[2*AW-1:AW]} : {1'b1, AW'(0)};
            top_dep_in  = '0;
            sp_in       = SPW'(1);
            state_in    = S_W_TOP;
         end
         S_W_TOP: begin
            if (top_next_ff[AW]) begin
               if (sp_ff == SPW'(1)) begin
                  i_in = '0;
                  state_in = S_B_L0;
               end else begin
                  state_in = S_W_POP;
               end
            end else begin
               state_in = S_W_ADJ;
            end
         end
         S_W_ADJ: begin
            top_next_in = lk_rd;
            state_in = S_W_TOP;
            if (child_ok && !(top_pv_ff && nb_rd == top_par_ff)) begin
               if (sp_ff >= SPW'(MAX_NODES) || seq_len_ff >= SLW'(MAX_SEQ)) begin
                  res_in.status = STS_TOUR;
                  res_in.tour_length = LEN_W'(seq_len_ff);
                  state_in = S_DONE;
               end else begin
                  sq_we = 1'b1;
                  sq_wd = {nb_rd, dep_next};
                  fp_we = 1'b1;
                  fp_wa = NIW'(nb_rd);
                  reached_in[NIW'(nb_rd)] = 1'b1;
                  seq_len_in = seq_len_ff + SLW'(1);
                  st_we = 1'b1;
                  ht_ra = NIW'(nb_rd);
                  child_in = nb_rd;
                  state_in = S_W_HEAD;
               end
            end
         end
         S_W_HEAD: begin
            top_node_in = child_ff;
            top_par_in  = top_node_ff;
            top_pv_in   = 1'b1;
            top_next_in = hv_ff[NIW'(child_ff)] ? {1'b0, ht_rd[2*AW-1:AW]}
                                                : {1'b1, AW'(0)};
            top_dep_in  = dep_next;
            sp_in       = sp_ff + SPW'(1);
            state_in    = S_W_TOP;
         end
         S_W_POP: begin
            top_node_in = st_rd[P_NOD +: NODE_W];
            top_par_in  = st_rd[P_PAR +: NODE_W];
            top_pv_in   = st_rd[P_PV];
            top_next_in = st_rd[P_NXT +: LKW];
            top_dep_in  = st_rd[DW-1:0];
            sp_in       = sp_ff - SPW'(1);
            if (seq_len_ff >= SLW'(MAX_SEQ)) begin
               res_in.status = STS_TOUR;
               res_in.tour_length = LEN_W'(seq_len_ff);
               state_in = S_DONE;
            end else begin
               sq_we = 1'b1;
               sq_wd = {st_rd[P_NOD +: NODE_W], st_rd[DW-1:0]};
               seq_len_in = seq_len_ff + SLW'(1);
               state_in = S_W_TOP;
            end
         end
         S_B_L0: begin
            rt_we = 1'b1;
            rt_wa = RTAW'({KW'(0), SW'(i_ff)});
            i_in = i_ff + SLW'(1);
            if (i_ff + SLW'(1) == seq_len_ff) begin
               i_in = '0;
               k_in = KCW'(1);
               if ((SLW + 1)'(2) > (SLW + 1)'(seq_len_ff)) begin
                  tour_ready_in = 1'b1;
                  res_in.tour_length = LEN_W'(seq_len_ff);
                  res_in.nodes_reported = LEN_W'(live_n);
                  state_in = S_DONE;
               end else begin
                  state_in = S_B_RA;
               end
            end
         end
         S_B_RA: begin
            rt_ra = RTAW'({KW'(k_ff - KCW'(1)), SW'(i_ff)});
            state_in = S_B_RB;
         end
         S_B_RB: begin
            x_in = rt_rd;
            rt_ra = RTAW'({KW'(k_ff - KCW'(1)),
                           SW'(i_ff + (SLW'(1) << (k_ff - KCW'(1))))});
            state_in = S_B_DA;
         end
         S_B_DA: begin
            y_in = rt_rd;
            sq_ra = x_ff;
            state_in = S_B_DB;
         end
         S_B_DB: begin
            dx_in = sq_rd[DW-1:0];
            sq_ra = y_ff;
            state_in = S_B_WR;
         end
         S_B_WR: begin
            rt_we = 1'b1;
            rt_wd = (dx_ff <= sq_rd[DW-1:0]) ? x_ff : y_ff;
            if (span_end <= (SLW + 1)'(seq_len_ff)) begin
               i_in = i_ff + SLW'(1);
               state_in = S_B_RA;
            end else if (k_next == KCW'(LV) || lvl_next > (SLW + 1)'(seq_len_ff)) begin
               tour_ready_in = 1'b1;
               res_in.tour_length = LEN_W'(seq_len_ff);
               res_in.nodes_reported = LEN_W'(live_n);
               state_in = S_DONE;
            end else begin
               i_in = '0;
               k_in = k_next;
               state_in = S_B_RA;
            end
         end
         S_Q_A: begin
            l_in = fp_rd;
            fp_ra = NIW'(b_ff);
            state_in = S_Q_B;
         end
         S_Q_B: begin
            l_in = q_lo;
            r_in = q_hi;
            k_in = KCW'(q_k);
            if (SLW'(q_hi) >= seq_len_ff) begin
               res_in.status = STS_TOUR;
               state_in = S_DONE;
            end else begin
               state_in = S_Q_K;
            end
         end
         S_Q_K: begin
            rt_ra = RTAW'({KW'(k_ff), l_ff});
            state_in = S_Q_RX;
         end
         S_Q_RX: begin
            x_in = rt_rd;
            rt_ra = RTAW'({KW'(k_ff), SW'(r_ff + SW'(1) - (SW'(1) << k_ff))});
            state_in = S_Q_RY;
         end
         S_Q_RY: begin
            y_in = rt_rd;
            sq_ra = x_ff;
            state_in = S_Q_DX;
         end
         S_Q_DX: begin
            dx_in = sq_rd[DW-1:0];
            sq_ra = y_ff;
            state_in = S_Q_DY;
         end
         S_Q_DY: begin
            sq_ra = (dx_ff <= sq_rd[DW-1:0]) ? x_ff : y_ff;
            state_in = S_Q_NODE;
         end
         S_Q_NODE: begin
            res_in.ancestor = sq_rd[SQW-1:DW];
            state_in = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign res = res_ff;

endmodule

### src/euler_tour_lca_engine.sv
// Channel  Dir  Payload                                          Accepted when
// req_if   in   command, node_a, node_b                          valid && ready
// rsp_if   out  status, ancestor, tour_length, nodes_reported    valid && ready
// csr_if   in   node_count                                       valid && ready
//
// One request at a time. A tour walks each adjacency list depth-first, pushing
// a child on the stack and popping it on return, appending to the sequence on
// both, then fills the sparse table level by level; its reads go one at a time
// through the single read port of the sequence and table memories.
// Reset clears control state and list and reach flags at once; no clearing pass.
// The response register frees the core while a response waits on rsp_if.ready.
module euler_tour_lca_engine #(
   parameter int MAX_NODES = eta_pkg::MAX_NODES_DEFAULT,
   parameter int MAX_ADJ   = eta_pkg::MAX_ADJ_DEFAULT,
   parameter int MAX_SEQ   = eta_pkg::MAX_SEQ_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   eta_chan_if.sink   req_if,
   eta_chan_if.source rsp_if,
   eta_chan_if.sink   csr_if
);

   import eta_pkg::*;

   logic [COUNT_W-1:0] node_count_ff, node_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               res_valid, res_ready;
   rsp_type            res;

   eta_core #(.MAX_NODES(MAX_NODES), .MAX_ADJ(MAX_ADJ), .MAX_SEQ(MAX_SEQ)) core (
      .clock,
      .reset,
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .req(req_if.data),
      .node_count(node_count_ff),
      .res_valid,
      .res_ready,
      .res
   );

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_if.valid) begin
         node_count_in = csr_if.data.node_count;
      end
      res_ready    = !rsp_valid_ff || rsp_if.ready;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule
